// ===== hdl/occupancy_grid_shape_rasterizer_defines.svh =====
// ---------------------------------------------------------------------------
// Occupancy grid shape rasterizer assertion macros
// Shared property forms used by the port checker of the rasterizer.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_SHAPE_RASTERIZER_DEFINES_SVH
`define OCCUPANCY_GRID_SHAPE_RASTERIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OGSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OGSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ogsr_pkg.sv =====
// ---------------------------------------------------------------------------
// Occupancy grid shape rasterizer package
// Sizes, codes, shared types and the bound conversion helper.
// ---------------------------------------------------------------------------
package ogsr_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int FRAC_BITS = 4;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int IDX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_COL_W = $clog2(MAX_COLS + 1);
    localparam int CNT_ROW_W = $clog2(MAX_ROWS + 1);
    localparam int CNT_W = (CNT_COL_W > CNT_ROW_W) ? CNT_COL_W : CNT_ROW_W;
    // Width in which the 9-bit size registers are compared with the limits.
    localparam int EXT_W = (CNT_W > 9) ? CNT_W : 9;
    // Width in which the 8-bit query coordinates become memory indexes.
    localparam int QX_W = (IDX_W > 8) ? IDX_W : 8;

    localparam int SIZE_W = 9;
    localparam int MARGIN_W = 10;
    localparam int CFG_DW = 10;
    localparam int CFG_AW = 2;

    localparam int POS_W = 14;
    localparam int LEN_W = 13;
    localparam int QRY_W = 8;

    // Box bounds carry one more fraction bit than the inputs.
    localparam int B_W = 20;
    localparam int HALF = 1 << FRAC_BITS;
    localparam int RCH_W = LEN_W + 1;
    localparam int R2_W = 2 * RCH_W;
    localparam int DX_W = ((IDX_W + FRAC_BITS > LEN_W) ? IDX_W + FRAC_BITS : LEN_W) + 2;
    localparam int SQ_W = 2 * DX_W;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_RECT   = 3'd1,
        REQ_CIRCLE = 3'd2,
        REQ_QUERY  = 3'd3,
        REQ_POINT  = 3'd4
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_UNKNOWN     = 2'd2,
        ST_OUTSIDE     = 2'd3
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        CFG_GRID_W = 2'd0,
        CFG_GRID_H = 2'd1,
        CFG_MARGIN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic [LEN_W-1:0]        size_w;
        logic [LEN_W-1:0]        size_h;
        logic [LEN_W-1:0]        radius;
        logic [QRY_W-1:0]        query_col;
        logic [QRY_W-1:0]        query_row;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]    lim_c;
        logic [CNT_W-1:0]    lim_r;
        logic [MARGIN_W-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] x0;
        logic [CNT_W-1:0] x1;
        logic [CNT_W-1:0] y0;
        logic [CNT_W-1:0] y1;
        logic [R2_W-1:0]  reach2;
    } t_box;

    typedef struct packed {
        logic    valid;
        logic    occ;
        t_status status;
    } t_res;

    // Bound with FRAC_BITS+1 fraction bits to a cell index, floored at zero
    // and capped at the grid size in use.
    function automatic logic [CNT_W-1:0] to_cell(input logic signed [B_W-1:0] v,
                                                 input logic [CNT_W-1:0] lim);
        logic signed [B_W-1:0] sh;
        logic signed [B_W-1:0] lim_s;
        logic [CNT_W-1:0]      res;
        sh = v >>> (FRAC_BITS + 1);
        lim_s = B_W'(lim);
        if (v <= 0) begin
            res = '0;
        end else if (sh > lim_s) begin
            res = lim;
        end else begin
            res = sh[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ogsr_row_ram.sv =====
// ---------------------------------------------------------------------------
// Occupancy grid row memory
// Simple dual-port synchronous RAM, one row of grid bits per entry.
// ---------------------------------------------------------------------------
module ogsr_row_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ogsr_bounds.sv =====
// ---------------------------------------------------------------------------
// Shape bounding box
// Clipped cell bounds of a rectangle or circle grown by the margin, and the
// squared reach of the circle test.
// ---------------------------------------------------------------------------
module ogsr_bounds
    import ogsr_pkg::*;
(
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_box o_box
);

    logic [RCH_W-1:0]      reach;
    logic signed [B_W-1:0] c2x;
    logic signed [B_W-1:0] c2y;
    logic signed [B_W-1:0] m2;
    logic signed [B_W-1:0] ex2;
    logic signed [B_W-1:0] ey2;
    logic signed [B_W-1:0] half;
    logic signed [B_W-1:0] lo_x;
    logic signed [B_W-1:0] hi_x;
    logic signed [B_W-1:0] lo_y;
    logic signed [B_W-1:0] hi_y;

    always_comb begin
        reach = RCH_W'(i_req.radius) + RCH_W'(i_cfg.margin);
        c2x   = B_W'($signed(i_req.center_x)) <<< 1;
        c2y   = B_W'($signed(i_req.center_y)) <<< 1;
        m2    = B_W'(i_cfg.margin) << 1;
        half  = B_W'(HALF);
        if (i_req.kind == REQ_CIRCLE) begin
            ex2 = B_W'(reach) << 1;
            ey2 = B_W'(reach) << 1;
        end else begin
            ex2 = B_W'(i_req.size_w) + m2;
            ey2 = B_W'(i_req.size_h) + m2;
        end
        lo_x = c2x - ex2;
        hi_x = c2x + ex2 + half;
        lo_y = c2y - ey2;
        hi_y = c2y + ey2 + half;

        o_box.x0     = to_cell(lo_x, i_cfg.lim_c);
        o_box.x1     = to_cell(hi_x, i_cfg.lim_c);
        o_box.y0     = to_cell(lo_y, i_cfg.lim_r);
        o_box.y1     = to_cell(hi_y, i_cfg.lim_r);
        o_box.reach2 = R2_W'(reach) * R2_W'(reach);
    end

endmodule

// ===== hdl/ogsr_engine.sv =====
// ---------------------------------------------------------------------------
// Rasterizer sequencer
// Walks the box row by row: reads a grid row, sets the covered cells in a
// row buffer one per cycle, writes the row back. Also clears and queries.
// ---------------------------------------------------------------------------
module ogsr_engine
    import ogsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    input  t_cfg i_cfg,
    input  logic i_out_free,
    output t_res o_res
);

    typedef enum logic [11:0] {
        S_INIT   = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_CLEAR  = 12'b0000_0000_0100,
        S_SETUP  = 12'b0000_0000_1000,
        S_ROW_RD = 12'b0000_0001_0000,
        S_ROW_LD = 12'b0000_0010_0000,
        S_CELL   = 12'b0000_0100_0000,
        S_DRAIN  = 12'b0000_1000_0000,
        S_WB     = 12'b0001_0000_0000,
        S_QRD    = 12'b0010_0000_0000,
        S_QSEL   = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_col, n_col;
    logic             r_p_valid, n_p_valid;

    t_req             r_req;
    t_box             r_box;
    t_box             box;
    logic             r_res_occ;
    t_status          r_res_st;
    t_status          st_init;
    logic [MAX_COLS-1:0] r_rowbuf;
    logic [SQ_W-1:0]  r_dx2;
    logic [SQ_W-1:0]  r_dy2;
    logic [COL_W-1:0] r_pcol;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [ROW_W-1:0]    ram_rd_addr;
    logic [MAX_COLS-1:0] ram_wr_data;
    logic [MAX_COLS-1:0] ram_rd_data;

    logic [QX_W-1:0]        q_col_x;
    logic [QX_W-1:0]        q_row_x;
    logic                   q_out;
    logic signed [DX_W-1:0] mul_base;
    logic signed [DX_W-1:0] mul_in;
    logic signed [SQ_W-1:0] mul_sq;
    logic                   hit;
    logic                   res_fire;

    ogsr_bounds u_bounds (
        .i_req (r_req),
        .i_cfg (i_cfg),
        .o_box (box)
    );

    ogsr_row_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_row[ROW_W-1:0]),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign q_col_x = QX_W'(r_req.query_col);
    assign q_row_x = QX_W'(r_req.query_row);
    assign q_out   = (EXT_W'(r_req.query_col) >= EXT_W'(i_cfg.lim_c)) ||
                     (EXT_W'(r_req.query_row) >= EXT_W'(i_cfg.lim_r));

    // One squarer: the row offset while a row is read, the column offset
    // while cells are walked.
    always_comb begin
        if (r_state == S_ROW_RD) begin
            mul_base = DX_W'(r_row) << FRAC_BITS;
            mul_in   = mul_base - DX_W'($signed(r_req.center_y));
        end else begin
            mul_base = DX_W'(r_col) << FRAC_BITS;
            mul_in   = mul_base - DX_W'($signed(r_req.center_x));
        end
        mul_sq = mul_in * mul_in;
    end

    assign hit = ({1'b0, r_dx2} + {1'b0, r_dy2}) <= (SQ_W + 1)'(r_box.reach2);

    always_comb begin
        unique case (i_req.kind)
            REQ_POINT:                                 st_init = ST_UNSUPPORTED;
            REQ_CLEAR, REQ_RECT, REQ_CIRCLE, REQ_QUERY: st_init = ST_OK;
            default:                                   st_init = ST_UNKNOWN;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_p_valid   = (r_state == S_CELL);
        ram_wr_en   = 1'b0;
        ram_wr_data = r_rowbuf;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_row[ROW_W-1:0];
        res_fire    = 1'b0;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
                if (r_row == CNT_W'(MAX_ROWS - 1)) begin
                    n_row   = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_FINISH;
                end else begin
                    n_row = CNT_W'(r_row + 1'b1);
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req.kind)
                        REQ_CLEAR: begin
                            n_row   = '0;
                            n_state = S_CLEAR;
                        end
                        REQ_RECT, REQ_CIRCLE: n_state = S_SETUP;
                        REQ_QUERY:            n_state = S_QRD;
                        default:              n_state = S_FINISH;
                    endcase
                end
            end
            S_SETUP: begin
                if (box.x0 >= box.x1 || box.y0 >= box.y1) begin
                    n_state = S_FINISH;
                end else begin
                    n_row   = box.y0;
                    n_state = S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                ram_rd_en = 1'b1;
                n_state   = S_ROW_LD;
            end
            S_ROW_LD: begin
                n_col   = r_box.x0;
                n_state = S_CELL;
            end
            S_CELL: begin
                n_col = CNT_W'(r_col + 1'b1);
                if (CNT_W'(r_col + 1'b1) == r_box.x1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_WB;
            S_WB: begin
                // The row is written back before the next one is read, so a
                // read never overlaps a pending write of the same entry.
                ram_wr_en = 1'b1;
                n_row     = CNT_W'(r_row + 1'b1);
                if (CNT_W'(r_row + 1'b1) == r_box.y1) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_ROW_RD;
                end
            end
            S_QRD: begin
                if (q_out) begin
                    n_state = S_FINISH;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = q_row_x[ROW_W-1:0];
                    n_state     = S_QSEL;
                end
            end
            S_QSEL: n_state = S_FINISH;
            S_FINISH: begin
                if (i_out_free) begin
                    res_fire = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_row     <= '0;
            r_col     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req     <= i_req;
            r_res_occ <= 1'b0;
            r_res_st  <= st_init;
        end
        if (r_state == S_QRD && q_out) begin
            r_res_st <= ST_OUTSIDE;
        end
        if (r_state == S_QSEL) begin
            r_res_occ <= ram_rd_data[q_col_x[COL_W-1:0]];
        end
        if (r_state == S_SETUP) begin
            r_box <= box;
        end
        if (r_state == S_ROW_RD) begin
            r_dy2 <= SQ_W'(mul_sq);
        end
        if (r_state == S_CELL) begin
            r_dx2  <= SQ_W'(mul_sq);
            r_pcol <= r_col[COL_W-1:0];
        end
        priority if (r_state == S_ROW_LD) begin
            r_rowbuf <= ram_rd_data;
        end else if (r_p_valid && (r_req.kind != REQ_CIRCLE || hit)) begin
            r_rowbuf[r_pcol] <= 1'b1;
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res.valid  = res_fire;
    assign o_res.occ    = r_res_occ;
    assign o_res.status = r_res_st;

endmodule

// ===== hdl/occupancy_grid_shape_rasterizer.sv =====
// ---------------------------------------------------------------------------
// Occupancy grid shape rasterizer
// Bit-per-cell occupancy grid with clear, rectangle, circle and query
// requests, one result beat per request beat.
// ---------------------------------------------------------------------------
// Requests enter on the s_axis channel, results leave on m_axis, and the
// grid size and safety margin are to be written on the i_cfg_* port while
// idle; the block does not enforce this. The grid sits in a 256-entry
// memory holding one grid row per entry. One request is processed at a
// time. Steps from accept to result valid:
//   point or unknown shape: no grid access
//   query:                  one memory read
//   clear:                  every memory row written, one row per cycle
//   rectangle or circle:    for each row of the clipped box, a read,
//                           load, one-cell-per-cycle walk, drain and write-back.
// After reset the block runs a clearing pass with s_axis_tready low;
// configuration writes are taken during it.
// A result waits in the output register while m_axis_tready is low; the
// next request is accepted meanwhile and its result is held back until
// the register is free.
module occupancy_grid_shape_rasterizer
    import ogsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // center_x[13:0], center_y[27:14], size_w[40:28], size_h[53:41],
    // radius[66:54], query_col[74:67], query_row[82:75], zero[87:83]
    input  logic [87:0]       s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // cell_occupied[0], zero[7:1]
    output logic [7:0]        m_axis_tdata,
    // status[1:0]
    output logic [1:0]        m_axis_tuser,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    logic [SIZE_W-1:0]   r_grid_w;
    logic [SIZE_W-1:0]   r_grid_h;
    logic [MARGIN_W-1:0] r_margin;
    logic                r_m_valid;
    logic                r_m_occ;
    t_status             r_m_status;

    t_req req;
    t_cfg cfg;
    t_res res;
    logic out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= SIZE_W'(256);
            r_grid_h <= SIZE_W'(256);
            r_margin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID_W: r_grid_w <= i_cfg_wdata[SIZE_W-1:0];
                CFG_GRID_H: r_grid_h <= i_cfg_wdata[SIZE_W-1:0];
                CFG_MARGIN: r_margin <= i_cfg_wdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes above the memory's extent are used as the extent.
    assign cfg.lim_c  = (EXT_W'(r_grid_w) > EXT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                              : CNT_W'(r_grid_w);
    assign cfg.lim_r  = (EXT_W'(r_grid_h) > EXT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                              : CNT_W'(r_grid_h);
    assign cfg.margin = r_margin;

    assign req.kind      = s_axis_tuser;
    assign req.center_x  = s_axis_tdata[13:0];
    assign req.center_y  = s_axis_tdata[27:14];
    assign req.size_w    = s_axis_tdata[40:28];
    assign req.size_h    = s_axis_tdata[53:41];
    assign req.radius    = s_axis_tdata[66:54];
    assign req.query_col = s_axis_tdata[74:67];
    assign req.query_row = s_axis_tdata[82:75];

    assign out_free = !r_m_valid || m_axis_tready;

    ogsr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res.valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_m_occ    <= res.occ;
            r_m_status <= res.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_m_occ};
    assign m_axis_tuser  = r_m_status;

endmodule

// ===== hdl/ogsr_checker.sv =====
// ---------------------------------------------------------------------------
// Rasterizer port checker
// Properties observed on the top level's ports, bound to every instance.
// ---------------------------------------------------------------------------
`include "occupancy_grid_shape_rasterizer_defines.svh"

module ogsr_checker
    import ogsr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result beat keeps its valid and its payload.
    `OGSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")

    // The clearing pass after reset keeps the request side closed.
    `OGSR_ASSERT_NOW(a_init_closed, $past(!i_rst_n), !s_axis_tready,
        "request taken during the clearing pass")

    // Only one request is in work at a time.
    `OGSR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "request taken while another is in work")

    // An occupied cell is only reported with an ok status.
    `OGSR_ASSERT_NOW(a_occ_ok, m_axis_tvalid && m_axis_tdata[0], m_axis_tuser == ST_OK,
        "occupied cell reported with an error status")

endmodule

bind occupancy_grid_shape_rasterizer ogsr_checker u_ogsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
